### sv/selective_repeat_receiver_macros.svh
// Assertion macros used by the checker file of the selective-repeat receiver.
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is low.
`define SRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising edge, off while reset is low.
`define SRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/srr_pkg.sv
// Shared types and constants of the selective-repeat receiver.
package srr_pkg;

    // Width of the window length register and its value after reset.
    localparam int WIN_BITS = 3;
    localparam logic [WIN_BITS-1:0] WIN_RESET = 3'd4;

    // Longest in-order run one packet can release.
    localparam int MAX_DELIVER = 4;

    // Classification of one accepted packet, passed from the front to the back.
    typedef struct packed {
        logic store;    // payload goes into the buffer and gets marked
        logic deliver;  // packet sits at the window base, so a delivery run follows
    } t_cmd_flags;

    localparam int FLAG_BITS = $bits(t_cmd_flags);

endpackage

### sv/srr_front.sv
// Front end: window register, packet acceptance and classification.
module srr_front #(
    parameter int SEQ_BITS = 3
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srr_pkg::WIN_BITS-1:0]   i_cfg_wdata,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic [SEQ_BITS-1:0]            i_seq_num,
    input  logic                           i_checksum_ok,
    input  logic [SEQ_BITS-1:0]            i_base,
    input  logic [(1 << SEQ_BITS)-1:0]     i_marks,
    output logic                           o_push,
    output srr_pkg::t_cmd_flags            o_flags
);

    localparam int HALF = 1 << (SEQ_BITS - 1);
    localparam int CAP  = (HALF < srr_pkg::MAX_DELIVER) ? HALF : srr_pkg::MAX_DELIVER;
    localparam int CW   = (SEQ_BITS > srr_pkg::WIN_BITS) ? SEQ_BITS : srr_pkg::WIN_BITS;

    logic [srr_pkg::WIN_BITS-1:0] r_window;
    logic [srr_pkg::WIN_BITS-1:0] n_window;
    logic [SEQ_BITS-1:0]          offset;
    logic [CW-1:0]                win_ext;
    logic [CW-1:0]                eff_win;
    logic                         in_window;

    assign n_window = i_cfg_we ? i_cfg_wdata : r_window;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= srr_pkg::WIN_RESET;
        end else begin
            r_window <= n_window;
        end
    end

    // The effective window saturates at the smaller of the run limit and half
    // the sequence space.
    always_comb begin
        win_ext   = CW'(r_window);
        eff_win   = (win_ext > CW'(CAP)) ? CW'(CAP) : win_ext;
        offset    = i_seq_num - i_base;
        in_window = CW'(offset) < eff_win;
    end

    always_comb begin
        o_push          = i_start && !i_busy && i_checksum_ok;
        o_flags.store   = in_window && !i_marks[i_seq_num];
        o_flags.deliver = o_flags.store && (offset == '0);
    end

endmodule

### sv/srr_queue.sv
// Two-entry command queue between the front and the back.
module srr_queue #(
    parameter int WIDTH = 69
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_slot [2];
    logic             r_wr_ptr;
    logic             n_wr_ptr;
    logic             r_rd_ptr;
    logic             n_rd_ptr;
    logic [1:0]       r_count;
    logic [1:0]       n_count;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        do_push  = i_push && (r_count != 2'd2);
        do_pop   = i_pop && (r_count != 2'd0);
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_slot[r_rd_ptr];
    assign o_empty = (r_count == 2'd0);

endmodule

### sv/srr_back.sv
// Back end: acknowledgement, payload buffer, marks and in-order delivery.
module srr_back #(
    parameter int SEQ_BITS     = 3,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [SEQ_BITS-1:0]         i_seq_num,
    input  logic [PAYLOAD_BITS-1:0]     i_data_word,
    input  srr_pkg::t_cmd_flags         i_flags,
    output logic                        o_pop,
    output logic                        o_busy,
    output logic [SEQ_BITS-1:0]         o_base,
    output logic [(1 << SEQ_BITS)-1:0]  o_marks,
    output logic                        o_result_valid,
    output logic                        o_kind,
    output logic [SEQ_BITS-1:0]         o_ack_num,
    output logic [PAYLOAD_BITS-1:0]     o_delivered_word,
    output logic                        o_last
);

    localparam int DEPTH = 1 << SEQ_BITS;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_SEND = 3'b100
    } t_back_state;

    t_back_state               r_state;
    t_back_state               n_state;
    logic [SEQ_BITS-1:0]       r_base;
    logic [SEQ_BITS-1:0]       n_base;
    logic [DEPTH-1:0]          r_marks;
    logic [DEPTH-1:0]          n_marks;
    logic                      r_more;
    logic                      n_more;
    logic                      r_out_valid;
    logic                      n_out_valid;
    logic                      r_out_kind;
    logic                      n_out_kind;
    logic [SEQ_BITS-1:0]       r_out_ack;
    logic [SEQ_BITS-1:0]       n_out_ack;
    logic [PAYLOAD_BITS-1:0]   r_out_word;
    logic [PAYLOAD_BITS-1:0]   n_out_word;
    logic                      r_out_last;
    logic                      n_out_last;
    logic [PAYLOAD_BITS-1:0]   r_rd_data;
    logic [PAYLOAD_BITS-1:0]   r_buf [DEPTH];
    logic                      buf_we;

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_marks     = r_marks;
        n_more      = r_more;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_ack   = r_out_ack;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        buf_we      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop       = 1'b1;
                    n_out_valid = 1'b1;
                    n_out_kind  = 1'b0;
                    n_out_ack   = i_seq_num;
                    n_out_word  = '0;
                    n_out_last  = !i_flags.deliver;
                    if (i_flags.store) begin
                        buf_we             = 1'b1;
                        n_marks[i_seq_num] = 1'b1;
                    end
                    if (i_flags.deliver) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                // Release the entry at the base and look one ahead for the run.
                n_marks[r_base] = 1'b0;
                n_base          = r_base + SEQ_BITS'(1);
                n_more          = r_marks[n_base];
                n_state         = ST_SEND;
            end
            ST_SEND: begin
                n_out_valid = 1'b1;
                n_out_kind  = 1'b1;
                n_out_ack   = '0;
                n_out_word  = r_rd_data;
                n_out_last  = !r_more;
                n_state     = r_more ? ST_READ : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_base      <= '0;
            r_marks     <= '0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_marks     <= n_marks;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_kind <= n_out_kind;
        r_out_ack  <= n_out_ack;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    // Payload buffer: one write port, one registered read port at the base.
    always_ff @(posedge i_clk) begin
        if (buf_we) begin
            r_buf[i_seq_num] <= i_data_word;
        end
        if (r_state == ST_READ) begin
            r_rd_data <= r_buf[r_base];
        end
    end

    assign o_busy           = (r_state != ST_IDLE);
    assign o_base           = r_base;
    assign o_marks          = r_marks;
    assign o_result_valid   = r_out_valid;
    assign o_kind           = r_out_kind;
    assign o_ack_num        = r_out_ack;
    assign o_delivered_word = r_out_word;
    assign o_last           = r_out_last;

endmodule

### sv/selective_repeat_receiver.sv
// Top level of the selective-repeat ARQ receiver.
//
//   Port group      Direction  Handshake                 Contents
//   packet in       input      start high, busy low      i_seq_num, i_checksum_ok, i_data_word
//   result out      output     o_result_valid, 1 cycle   o_kind, o_ack_num, o_delivered_word,
//                                                        o_last
//   window length   input      i_cfg_we                  i_cfg_wdata
//
// A corrupt packet is dropped and busy stays low. A good packet keeps busy high
// while it waits in the queue; each in-order delivery it releases keeps busy
// high for one more buffer read and one more result. The delivery loop through
// the single read port of the payload buffer sets how soon the next packet can
// be accepted. Reset is synchronous and active low; it clears the window base,
// all marks and the queue, and sets the window length to four. The result
// side cannot stall: each result shows for exactly one cycle.
module selective_repeat_receiver #(
    parameter int SEQ_BITS     = 3,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Window length register.
    input  logic                          i_cfg_we,
    input  logic [srr_pkg::WIN_BITS-1:0]  i_cfg_wdata,
    // Packet in.
    input  logic                          start,
    output logic                          busy,
    input  logic [SEQ_BITS-1:0]           i_seq_num,
    input  logic                          i_checksum_ok,
    input  logic [PAYLOAD_BITS-1:0]       i_data_word,
    // Results out.
    output logic                          o_result_valid,
    output logic                          o_kind,
    output logic [SEQ_BITS-1:0]           o_ack_num,
    output logic [PAYLOAD_BITS-1:0]       o_delivered_word,
    output logic                          o_last
);

    localparam int DEPTH   = 1 << SEQ_BITS;
    localparam int Q_WIDTH = srr_pkg::FLAG_BITS + SEQ_BITS + PAYLOAD_BITS;

    logic                    push;
    srr_pkg::t_cmd_flags     push_flags;
    logic [Q_WIDTH-1:0]      q_in;
    logic [Q_WIDTH-1:0]      q_out;
    logic                    q_empty;
    logic                    pop;
    logic                    back_busy;
    logic [SEQ_BITS-1:0]     base;
    logic [DEPTH-1:0]        marks;
    srr_pkg::t_cmd_flags     cmd_flags;
    logic [SEQ_BITS-1:0]     cmd_seq;
    logic [PAYLOAD_BITS-1:0] cmd_data;

    // The front only classifies a packet while nothing is queued and the back
    // is idle, so the base and marks it looks at are final for that packet.
    assign busy = !q_empty || back_busy;

    srr_front #(
        .SEQ_BITS (SEQ_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_start       (start),
        .i_busy        (busy),
        .i_seq_num     (i_seq_num),
        .i_checksum_ok (i_checksum_ok),
        .i_base        (base),
        .i_marks       (marks),
        .o_push        (push),
        .o_flags       (push_flags)
    );

    assign q_in = {push_flags, i_seq_num, i_data_word};

    srr_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign {cmd_flags, cmd_seq, cmd_data} = q_out;

    srr_back #(
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!q_empty),
        .i_seq_num        (cmd_seq),
        .i_data_word      (cmd_data),
        .i_flags          (cmd_flags),
        .o_pop            (pop),
        .o_busy           (back_busy),
        .o_base           (base),
        .o_marks          (marks),
        .o_result_valid   (o_result_valid),
        .o_kind           (o_kind),
        .o_ack_num        (o_ack_num),
        .o_delivered_word (o_delivered_word),
        .o_last           (o_last)
    );

endmodule

### sv/srr_checker.sv
// Port-level checker for the selective-repeat receiver, with its bind.
`include "selective_repeat_receiver_macros.svh"

module srr_checker #(
    parameter int SEQ_BITS     = 3,
    parameter int PAYLOAD_BITS = 64
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    i_checksum_ok,
    input logic                    o_result_valid,
    input logic                    o_kind,
    input logic [SEQ_BITS-1:0]     o_ack_num,
    input logic [PAYLOAD_BITS-1:0] o_delivered_word
);

    // A good packet always occupies the block for at least the next cycle.
    `SRR_ASSERT_NEXT(a_good_sets_busy, i_clk, i_rst_n, start && !busy && i_checksum_ok, busy, "good item did not raise busy")

    // A corrupt packet leaves the block idle and gives no result.
    `SRR_ASSERT_NEXT(a_bad_dropped, i_clk, i_rst_n, start && !busy && !i_checksum_ok, !busy && !o_result_valid, "corrupt item was not dropped")

    // Results never come in back-to-back cycles.
    `SRR_ASSERT_NEXT(a_result_spacing, i_clk, i_rst_n, o_result_valid, !o_result_valid, "results in back-to-back cycles")

    // Each result kind zeroes the field that belongs to the other kind.
    `SRR_ASSERT_NOW(a_kind_fields, i_clk, i_rst_n, o_result_valid, (o_kind && (o_ack_num == '0)) || (!o_kind && (o_delivered_word == '0)), "result field not zero for its kind")

endmodule

bind selective_repeat_receiver srr_checker #(
    .SEQ_BITS     (SEQ_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_srr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_checksum_ok    (i_checksum_ok),
    .o_result_valid   (o_result_valid),
    .o_kind           (o_kind),
    .o_ack_num        (o_ack_num),
    .o_delivered_word (o_delivered_word)
);
